/* rtl/lpsa_pkg.sv */
// Shared types, constants and codes for the lidar packet sweep assembler.
package lpsa_pkg;

  localparam int MAX_PACKET_POINTS = 16;
  localparam int SWEEP_DEPTH = 25;

  localparam logic [16:0] FULL_TURN = 17'd36000;
  localparam logic [15:0] INVALID_RANGE = 16'hFFFF;
  localparam logic [15:0] WRAP_LOW = 16'd500;
  localparam logic [15:0] WRAP_HIGH = 16'd35500;
  localparam int MIN_SWEEP = 10;
  localparam int MIN_VALID = 3;
  localparam int ANGLE_DIV_W = 16;

  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_POINTS = 3'd6;

  localparam logic signed [16:0] ANGLE_OFFSET_RST = 17'sd0;
  localparam logic [15:0] WINDOW_MIN_RST = 16'd0;
  localparam logic [16:0] WINDOW_MAX_RST = 17'd36000;
  localparam logic [15:0] RANGE_MIN_RST = 16'd0;
  localparam logic [15:0] RANGE_MAX_RST = 16'd65535;
  localparam logic [4:0] SWEEP_LIMIT_RST = 5'd25;
  localparam logic [4:0] PACKET_POINTS_RST = 5'd16;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] start_angle_raw;
    logic [15:0] end_angle_raw;
    logic [15:0] near_range_raw;
    logic [7:0]  near_intensity;
    logic [15:0] far_range_raw;
    logic [7:0]  far_intensity;
  } req_t;

  typedef struct packed {
    logic [4:0]  point_index;
    logic [15:0] angle_hundredths;
    logic [15:0] near_range_mm;
    logic [7:0]  near_level;
    logic [15:0] far_range_mm;
    logic [7:0]  far_level;
    logic        last_of_sweep;
  } rsp_t;

  typedef struct packed {
    logic [15:0] nr;
    logic [7:0]  ni;
    logic [15:0] fr;
    logic [7:0]  fi;
  } pkt_entry_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] nr;
    logic [7:0]  ni;
    logic [15:0] fr;
    logic [7:0]  fi;
  } sweep_entry_t;

  typedef struct packed {
    logic req_take;
    logic div_start;
    logic walk_init;
    logic pt_step;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic rec_last;
    logic rec_enough;
    logic div_done;
    logic walk_last;
    logic walk_done;
    logic close_emit;
    logic emit_last;
    logic rsp_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_PT,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_t;

endpackage

/* rtl/lpsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lpsa_div.sv */
// Restoring divider, one quotient bit per cycle.
module lpsa_div #(
  parameter int NW = 16,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[NW-1]};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CW'(NW - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

/* rtl/lpsa_ctrl.sv */
// Controller state machine: sequences packet intake, division, point walk and emission.
module lpsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lpsa_pkg::sts_t sts,
  output lpsa_pkg::cmd_t cmd
);

  lpsa_pkg::state_t state;
  lpsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      lpsa_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.req_take = 1'b1;
          if (sts.rec_last && sts.rec_enough) begin
            cmd.div_start = 1'b1;
            state_next = lpsa_pkg::ST_DIV;
          end
        end
      end
      lpsa_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.walk_init = 1'b1;
          state_next = lpsa_pkg::ST_RD;
        end
      end
      lpsa_pkg::ST_RD: begin
        state_next = lpsa_pkg::ST_PT;
      end
      lpsa_pkg::ST_PT: begin
        cmd.pt_step = 1'b1;
        if (sts.close_emit) begin
          state_next = lpsa_pkg::ST_EMIT_RD;
        end else if (sts.walk_last) begin
          state_next = lpsa_pkg::ST_IDLE;
        end else begin
          state_next = lpsa_pkg::ST_RD;
        end
      end
      lpsa_pkg::ST_EMIT_RD: begin
        state_next = lpsa_pkg::ST_EMIT_LOAD;
      end
      lpsa_pkg::ST_EMIT_LOAD: begin
        if (sts.rsp_free) begin
          cmd.emit_load = 1'b1;
          if (!sts.emit_last) begin
            state_next = lpsa_pkg::ST_EMIT_RD;
          end else if (sts.walk_done) begin
            state_next = lpsa_pkg::ST_IDLE;
          end else begin
            state_next = lpsa_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_next = lpsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/lpsa_dp.sv */
// Datapath: configuration, packet and sweep stores, angle arithmetic and result register.
module lpsa_dp #(
  parameter int MAX_PACKET_POINTS = lpsa_pkg::MAX_PACKET_POINTS,
  parameter int SWEEP_DEPTH = lpsa_pkg::SWEEP_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lpsa_pkg::req_t                 req_data,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lpsa_pkg::rsp_t                 rsp_data,
  input  logic                           cfg_we,
  input  logic [lpsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpsa_pkg::CFG_W-1:0]     cfg_data,
  input  lpsa_pkg::cmd_t                 cmd,
  output lpsa_pkg::sts_t                 sts
);

  localparam int PW = $clog2(MAX_PACKET_POINTS + 1);
  localparam int AW = $clog2(MAX_PACKET_POINTS);
  localparam int SIW = $clog2(SWEEP_DEPTH + 1);
  localparam int SAW = $clog2(SWEEP_DEPTH);
  localparam int SUMW = SIW + 1;
  localparam int PKT_W = $bits(lpsa_pkg::pkt_entry_t);
  localparam int SWP_W = $bits(lpsa_pkg::sweep_entry_t);

  // Configuration registers.
  logic signed [16:0] angle_offset;
  logic [15:0]        window_min;
  logic [16:0]        window_max;
  logic [15:0]        range_min_mm;
  logic [15:0]        range_max_mm;
  logic [4:0]         sweep_limit;
  logic [4:0]         packet_points;

  // Packet and sweep state.
  logic [PW-1:0]   rec_cnt;
  logic [PW-1:0]   val_cnt;
  logic [15:0]     start_angle;
  logic [15:0]     span;
  logic [SIW-1:0]  sweep_idx;
  logic [15:0]     prev_angle;
  logic [PW-1:0]   pp_lat;
  logic [PW-1:0]   num;
  logic [15:0]     acc;
  logic [SIW-1:0]  nres;
  logic [SIW-1:0]  k;
  logic [SIW-1:0]  emit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= lpsa_pkg::ANGLE_OFFSET_RST;
      window_min <= lpsa_pkg::WINDOW_MIN_RST;
      window_max <= lpsa_pkg::WINDOW_MAX_RST;
      range_min_mm <= lpsa_pkg::RANGE_MIN_RST;
      range_max_mm <= lpsa_pkg::RANGE_MAX_RST;
      sweep_limit <= lpsa_pkg::SWEEP_LIMIT_RST;
      packet_points <= lpsa_pkg::PACKET_POINTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lpsa_pkg::CFG_ANGLE_OFFSET: angle_offset <= signed'(cfg_data);
        lpsa_pkg::CFG_WINDOW_MIN: window_min <= cfg_data[15:0];
        lpsa_pkg::CFG_WINDOW_MAX: window_max <= cfg_data;
        lpsa_pkg::CFG_RANGE_MIN: range_min_mm <= cfg_data[15:0];
        lpsa_pkg::CFG_RANGE_MAX: range_max_mm <= cfg_data[15:0];
        lpsa_pkg::CFG_SWEEP_LIMIT: sweep_limit <= cfg_data[4:0];
        lpsa_pkg::CFG_PACKET_POINTS: packet_points <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Header arithmetic: offset start angle, fold into one turn, span to end.
  localparam logic signed [18:0] TURN_S = 19'sd36000;
  logic signed [18:0] s0, s1, s2, s3, s4, s5;
  logic [16:0]        end_w;
  logic [16:0]        start_w;
  logic [16:0]        span_w;

  always_comb begin
    s0 = signed'({3'b000, req_data.start_angle_raw}) + 19'(angle_offset);
    s1 = (s0 < 0) ? s0 + TURN_S : s0;
    s2 = (s1 < 0) ? s1 + TURN_S : s1;
    s3 = (s2 > TURN_S) ? s2 - TURN_S : s2;
    s4 = (s3 > TURN_S) ? s3 - TURN_S : s3;
    s5 = (s4 > TURN_S) ? s4 - TURN_S : s4;
    start_w = s5[16:0];
    end_w = {1'b0, req_data.end_angle_raw};
    if (end_w > lpsa_pkg::FULL_TURN) begin
      end_w = end_w - lpsa_pkg::FULL_TURN;
    end
    span_w = (start_w > end_w) ? end_w + lpsa_pkg::FULL_TURN - start_w : end_w - start_w;
  end

  // Record intake.
  logic [7:0]    pp8;
  logic [7:0]    pp_c;
  logic [PW-1:0] pp_now;
  logic [PW-1:0] rec_base;
  logic [PW-1:0] val_base;
  logic [PW-1:0] rec_new;
  logic [PW-1:0] val_new;
  logic          rec_ok;
  logic          is_rec;

  always_comb begin
    pp8 = 8'(packet_points);
    if (pp8 < 8'd1) begin
      pp_c = 8'd1;
    end else if (pp8 > 8'(MAX_PACKET_POINTS)) begin
      pp_c = 8'(MAX_PACKET_POINTS);
    end else begin
      pp_c = pp8;
    end
    pp_now = PW'(pp_c);
    rec_base = (rec_cnt >= pp_now) ? '0 : rec_cnt;
    val_base = (rec_cnt >= pp_now) ? '0 : val_cnt;
    rec_ok = req_data.near_range_raw != lpsa_pkg::INVALID_RANGE;
    rec_new = rec_base + 1'b1;
    val_new = val_base + PW'(rec_ok);
    is_rec = req_data.opcode == lpsa_pkg::OP_RECORD;
  end

  lpsa_pkg::pkt_entry_t pkt_wr;
  logic [PKT_W-1:0]     pkt_rdata;
  lpsa_pkg::pkt_entry_t pkt_rd;

  assign pkt_wr = '{nr: req_data.near_range_raw, ni: req_data.near_intensity,
                    fr: req_data.far_range_raw, fi: req_data.far_intensity};
  assign pkt_rd = pkt_rdata;

  lpsa_ram #(.WIDTH(PKT_W), .DEPTH(MAX_PACKET_POINTS)) u_pkt_ram (
    .clk  (clk),
    .we   (cmd.req_take && is_rec),
    .waddr(rec_base[AW-1:0]),
    .wdata(pkt_wr),
    .raddr(num[AW-1:0]),
    .rdata(pkt_rdata)
  );

  // Angle step = span / (valid records - 1).
  logic [15:0] step;
  logic        div_done;

  lpsa_div #(.NW(lpsa_pkg::ANGLE_DIV_W), .DW(PW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(span),
    .divisor (val_new - 1'b1),
    .quotient(step),
    .done    (div_done)
  );

  // Point walk.
  logic [16:0]   acc_sum;
  logic [15:0]   acc_next;
  logic          pt_valid;
  logic          wrap;
  logic [7:0]    lim8;
  logic          close;
  logic [SUMW-1:0] fit_sum;
  logic          fits;

  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, step};
    acc_next = (acc_sum > lpsa_pkg::FULL_TURN) ? 16'(acc_sum - lpsa_pkg::FULL_TURN)
                                              : acc_sum[15:0];
    pt_valid = pkt_rd.nr != lpsa_pkg::INVALID_RANGE;
    wrap = (acc < prev_angle) && (acc < lpsa_pkg::WRAP_LOW) &&
           (prev_angle > lpsa_pkg::WRAP_HIGH);
    lim8 = (8'(sweep_limit) > 8'(SWEEP_DEPTH)) ? 8'(SWEEP_DEPTH) : 8'(sweep_limit);
    close = (wrap || (8'(sweep_idx) >= lim8)) && (8'(sweep_idx) > 8'(lpsa_pkg::MIN_SWEEP));
    fit_sum = SUMW'(nres) + SUMW'(sweep_idx);
    fits = fit_sum <= SUMW'(SWEEP_DEPTH);
  end

  lpsa_pkg::sweep_entry_t swp_wr;
  logic [SWP_W-1:0]       swp_rdata;
  lpsa_pkg::sweep_entry_t swp_rd;

  assign swp_wr = '{angle: acc, nr: pkt_rd.nr, ni: pkt_rd.ni, fr: pkt_rd.fr, fi: pkt_rd.fi};
  assign swp_rd = swp_rdata;

  lpsa_ram #(.WIDTH(SWP_W), .DEPTH(SWEEP_DEPTH)) u_swp_ram (
    .clk  (clk),
    .we   (cmd.pt_step && pt_valid && !close && (sweep_idx < SIW'(SWEEP_DEPTH))),
    .waddr(sweep_idx[SAW-1:0]),
    .wdata(swp_wr),
    .raddr(k[SAW-1:0]),
    .rdata(swp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_cnt <= '0;
      val_cnt <= '0;
      start_angle <= '0;
      span <= '0;
      sweep_idx <= '0;
      prev_angle <= '0;
    end else begin
      if (cmd.req_take) begin
        if (!is_rec) begin
          start_angle <= start_w[15:0];
          span <= span_w[15:0];
          rec_cnt <= '0;
          val_cnt <= '0;
        end else if (rec_new == pp_now) begin
          rec_cnt <= '0;
          val_cnt <= '0;
        end else begin
          rec_cnt <= rec_new;
          val_cnt <= val_new;
        end
      end
      if (cmd.pt_step && pt_valid) begin
        prev_angle <= acc;
        sweep_idx <= close ? '0 : sweep_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_take && is_rec) begin
      pp_lat <= pp_now;
    end
    if (cmd.walk_init) begin
      num <= '0;
      acc <= start_angle;
      nres <= '0;
    end else if (cmd.pt_step) begin
      num <= num + 1'b1;
      acc <= acc_next;
      if (pt_valid && close && fits) begin
        emit_cnt <= sweep_idx;
        k <= '0;
        nres <= SIW'(fit_sum);
      end
    end else if (cmd.emit_load) begin
      k <= k + 1'b1;
    end
  end

  // Window and range filter on the entry being emitted.
  logic [16:0] mirror;
  logic        out_win;
  logic [15:0] nr_f;
  logic [15:0] fr_f;

  always_comb begin
    mirror = lpsa_pkg::FULL_TURN - {1'b0, swp_rd.angle};
    if (window_max > lpsa_pkg::FULL_TURN) begin
      out_win = (mirror > window_max - lpsa_pkg::FULL_TURN) && (mirror < {1'b0, window_min});
    end else begin
      out_win = (mirror > window_max) || (mirror < {1'b0, window_min});
    end
    nr_f = out_win ? 16'd0 : swp_rd.nr;
    fr_f = out_win ? 16'd0 : swp_rd.fr;
    if (nr_f < range_min_mm || nr_f > range_max_mm) begin
      nr_f = 16'd0;
    end
    if (fr_f < range_min_mm || fr_f > range_max_mm) begin
      fr_f = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      rsp_data <= '{point_index: 5'(k), angle_hundredths: swp_rd.angle,
                    near_range_mm: nr_f, near_level: swp_rd.ni,
                    far_range_mm: fr_f, far_level: swp_rd.fi,
                    last_of_sweep: (k + 1'b1) == emit_cnt};
    end
  end

  always_comb begin
    sts.rec_last = is_rec && (rec_new == pp_now);
    sts.rec_enough = val_new >= PW'(lpsa_pkg::MIN_VALID);
    sts.div_done = div_done;
    sts.walk_last = ({1'b0, num} + 1'b1) == {1'b0, pp_lat};
    sts.walk_done = num == pp_lat;
    sts.close_emit = pt_valid && close && fits;
    sts.emit_last = (k + 1'b1) == emit_cnt;
    sts.rsp_free = !rsp_valid || !rsp_stall;
  end

endmodule

/* rtl/lidar_packet_sweep_assembler_core.sv */
// Sequence: a header or a non-final record is taken while idle; a packet's final record with
// at least three valid records starts the divider, then each record slot is read and walked
// and each emitted point is read and loaded, waiting while the result register is stalled.
// Requests are taken one per cycle while idle between packets; division, walk and emission hold them off.
// Reset (rst, synchronous, active high) restores default configuration and clears the
// packet and sweep counters; the packet and sweep stores are not cleared.
module lidar_packet_sweep_assembler_core #(
  parameter int MAX_PACKET_POINTS = lpsa_pkg::MAX_PACKET_POINTS,
  parameter int SWEEP_DEPTH = lpsa_pkg::SWEEP_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel: headers and point records.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lpsa_pkg::req_t                 req_data,
  // Result channel: one filtered point of a closed sweep per transfer.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lpsa_pkg::rsp_t                 rsp_data,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [lpsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpsa_pkg::CFG_W-1:0]     cfg_data
);

  // The controller only takes a request while idle. A completed packet with at
  // least three valid records runs the divider for the angle step, then walks the
  // buffered records one at a time, appending points to the sweep store. When a
  // sweep closes, the walk pauses and the stored points are sent out through the
  // result register before the walk resumes, so the store is never overwritten
  // while it is still being emitted.
  lpsa_pkg::cmd_t cmd;
  lpsa_pkg::sts_t sts;

  lpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration registers, both stores, the divider
  // and the result register, which decouples the result side from the walk.
  lpsa_dp #(
    .MAX_PACKET_POINTS(MAX_PACKET_POINTS),
    .SWEEP_DEPTH      (SWEEP_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
